@@ hdl/ase_pkg.sv @@
// Shared constants, types and divider step functions for the ATA sector address encoder.
`default_nettype none

package ase_pkg;

  // Configuration port geometry.
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ID_FLAGS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_SECTORS = 3'd1;
  localparam logic [IDX_W-1:0] REG_CUR_HEADS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CUR_SECTORS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CUR_CYLINDERS = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEF_HEADS     = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEF_SECTORS   = 3'd6;
  localparam logic [IDX_W-1:0] REG_DEF_CYLINDERS = 3'd7;

  // Addressing modes.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;
  localparam logic [1:0] MODE_CUR   = 2'd2;
  localparam logic [1:0] MODE_DEF   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DRIVE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Geometry limits and fallbacks.
  localparam logic [28:0] LBA28_LIMIT      = 29'h1000_0000;
  localparam logic [15:0] MAX_HEADS        = 16'd16;
  localparam logic [15:0] MAX_SECTORS      = 16'd255;
  localparam logic [16:0] CYL_DEFAULT      = 17'h1_0000;
  localparam logic [15:0] FALLBACK_HEADS   = 16'd16;
  localparam logic [15:0] FALLBACK_SECTORS = 16'd63;

  // Drive/head register bits.
  localparam logic [7:0] DH_BASE  = 8'hA0;
  localparam logic [7:0] DH_LBA   = 8'h40;
  localparam logic [7:0] DH_SLAVE = 8'h10;

  // Divider shape: LBA below 2^28 split by heads*sectors into a 16-bit cylinder
  // and a 12-bit remainder, then the remainder split by sectors into a 4-bit head.
  localparam int LBA_BITS  = 28;
  localparam int CYL_BITS  = 16;
  localparam int REM_BITS  = LBA_BITS - CYL_BITS;
  localparam int HEAD_BITS = 4;

  // Accept edge to the edge that samples the result strobe.
  localparam int PIPE_LATENCY = 3 + CYL_BITS + HEAD_BITS + 1;

  // Stage 1: chosen geometry.
  typedef struct packed {
    logic        drv;
    logic [1:0]  mode;
    logic [4:0]  hd;
    logic [7:0]  sp;
    logic [11:0] hs;
    logic [16:0] cyl;
    logic [28:0] tlim;
    logic [31:0] lba;
    logic [31:0] cnt;
  } s1_t;

  // Stage 2: sector limit.
  typedef struct packed {
    logic        drv;
    logic [1:0]  mode;
    logic [4:0]  hd;
    logic [7:0]  sp;
    logic [11:0] hs;
    logic [28:0] lim;
    logic [31:0] lba;
    logic [31:0] cnt;
  } s2_t;

  // Stage 3: start compare and headroom.
  typedef struct packed {
    logic        drv;
    logic [1:0]  mode;
    logic [4:0]  hd;
    logic [7:0]  sp;
    logic [11:0] hs;
    logic [28:0] lim;
    logic [31:0] lba;
    logic [31:0] cnt;
    logic        lt;
    logic [28:0] diff;
  } s3_t;

  // Divider stages.
  typedef struct packed {
    logic                drv;
    logic [1:0]          mode;
    logic [1:0]          status;
    logic                rok;
    logic [4:0]          hd;
    logic [7:0]          sp;
    logic [11:0]         hs;
    logic [28:0]         lim;
    logic [LBA_BITS-1:0] lba;
    logic [CYL_BITS-1:0] quo;
    logic [REM_BITS-1:0] rem;
    logic [HEAD_BITS-1:0] low;
    logic [HEAD_BITS-1:0] head;
  } dv_t;

  typedef struct packed {
    logic        q;
    logic [11:0] rem;
  } step12_t;

  typedef struct packed {
    logic       q;
    logic [7:0] rem;
  } step8_t;

  // One restoring division step on a 12-bit remainder.
  function automatic step12_t div_step12(input logic [11:0] rem_in, input logic nbit,
                                         input logic [11:0] dvsr);
    logic [12:0] t;
    step12_t     r;
    t = {rem_in, nbit};
    if (t >= {1'b0, dvsr}) begin
      r.q   = 1'b1;
      r.rem = 12'(t - {1'b0, dvsr});
    end else begin
      r.q   = 1'b0;
      r.rem = t[11:0];
    end
    return r;
  endfunction

  // One restoring division step on an 8-bit remainder.
  function automatic step8_t div_step8(input logic [7:0] rem_in, input logic nbit,
                                       input logic [7:0] dvsr);
    logic [8:0] t;
    step8_t     r;
    t = {rem_in, nbit};
    if (t >= {1'b0, dvsr}) begin
      r.q   = 1'b1;
      r.rem = 8'(t - {1'b0, dvsr});
    end else begin
      r.q   = 1'b0;
      r.rem = t[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ata_sector_address_encoder_top.sv @@
// Top level of the ATA sector address encoder: geometry selection, range check and task file.
//
// The block takes one transaction per clock and returns each result in order,
// as a one-cycle strobe on out_valid; the receiver cannot stall it and nothing
// inside ever holds off the input, so busy is high only while reset is held and
// for the cycle after.
// The depth is set by the CHS split: a restoring divider by heads*sectors that
// resolves one cylinder bit per stage (16 stages), then a divider by sectors
// that resolves one head bit per stage (4 stages), behind three stages that
// pick the geometry, multiply out the sector limit and compare the range.
// Configuration writes are taken whenever cfg_ready is high and must only be
// issued while no transaction is in flight.
`default_nettype none

module ata_sector_address_encoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Command channel.
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_drive_select,
  input  wire logic [31:0]                 in_start_sector,
  input  wire logic [31:0]                 in_sector_count,
  // Configuration channel.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ase_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [ase_pkg::DATA_W-1:0]  cfg_data,
  // Result channel.
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [1:0]                       out_addr_mode,
  output logic                             out_range_ok,
  output logic [7:0]                       out_sector_number,
  output logic [7:0]                       out_cylinder_low,
  output logic [7:0]                       out_cylinder_high,
  output logic [7:0]                       out_drive_head,
  output logic [4:0]                       out_heads_used,
  output logic [7:0]                       out_sectors_used,
  output logic [28:0]                      out_sector_limit
);
  import ase_pkg::*;

  // Configuration registers.
  logic [2:0]  id_flags_r;
  logic [31:0] total_sectors_r;
  logic [15:0] cur_heads_r;
  logic [15:0] cur_sectors_r;
  logic [15:0] cur_cylinders_r;
  logic [15:0] def_heads_r;
  logic [15:0] def_sectors_r;
  logic [15:0] def_cylinders_r;

  logic ready_r;
  logic accept;

  // Pipeline registers and valid bits.
  logic                 v1_r, v2_r, v3_r;
  s1_t                  s1_r, s1_nxt;
  s2_t                  s2_r, s2_nxt;
  s3_t                  s3_r, s3_nxt;
  logic [CYL_BITS-1:0]  dv_v_r;
  logic [HEAD_BITS-1:0] hr_v_r;
  dv_t                  dv_first;
  dv_t                  dv_in  [CYL_BITS];
  dv_t                  dv_nxt [CYL_BITS];
  dv_t                  dv_r   [CYL_BITS];
  step12_t              cyl_step [CYL_BITS];
  dv_t                  hr_in  [HEAD_BITS];
  dv_t                  hr_nxt [HEAD_BITS];
  dv_t                  hr_r   [HEAD_BITS];
  step8_t               head_step [HEAD_BITS];

  // Geometry selection terms.
  logic        cur_ok;
  logic        def_fit;
  logic [15:0] def_h16;
  logic [15:0] def_s16;
  logic [28:0] tlim;

  // Output registers.
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        rok_r, rok_nxt;
  logic [7:0]  b0_r, b0_nxt;
  logic [7:0]  b1_r, b1_nxt;
  logic [7:0]  b2_r, b2_nxt;
  logic [7:0]  b3_r, b3_nxt;
  logic [4:0]  hd_r, hd_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [28:0] lim_r, lim_nxt;
  logic [7:0]  slave_bit;

  // Ready is registered and comes up in the cycle after reset is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign busy      = !ready_r;
  assign cfg_ready = ready_r;
  assign accept    = start && ready_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_flags_r      <= '0;
      total_sectors_r <= '0;
      cur_heads_r     <= '0;
      cur_sectors_r   <= '0;
      cur_cylinders_r <= '0;
      def_heads_r     <= '0;
      def_sectors_r   <= '0;
      def_cylinders_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ID_FLAGS:      id_flags_r      <= cfg_data[2:0];
        REG_TOTAL_SECTORS: total_sectors_r <= cfg_data;
        REG_CUR_HEADS:     cur_heads_r     <= cfg_data[15:0];
        REG_CUR_SECTORS:   cur_sectors_r   <= cfg_data[15:0];
        REG_CUR_CYLINDERS: cur_cylinders_r <= cfg_data[15:0];
        REG_DEF_HEADS:     def_heads_r     <= cfg_data[15:0];
        REG_DEF_SECTORS:   def_sectors_r   <= cfg_data[15:0];
        REG_DEF_CYLINDERS: def_cylinders_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits travel alongside the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      dv_v_r      <= '0;
      hr_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      dv_v_r      <= {dv_v_r[CYL_BITS-2:0], v3_r};
      hr_v_r      <= {hr_v_r[HEAD_BITS-2:0], dv_v_r[CYL_BITS-1]};
      out_valid_r <= hr_v_r[HEAD_BITS-1];
    end
  end

  // Stage 1: pick the addressing mode and geometry, form heads*sectors.
  always_comb begin
    cur_ok = id_flags_r[2] && (cur_heads_r != '0) && (cur_heads_r <= MAX_HEADS) &&
             (cur_sectors_r != '0) && (cur_sectors_r <= MAX_SECTORS) &&
             (cur_cylinders_r != '0);
    def_h16 = (def_heads_r == '0) ? FALLBACK_HEADS : def_heads_r;
    def_s16 = (def_sectors_r == '0) ? FALLBACK_SECTORS : def_sectors_r;
    def_fit = (def_h16 <= MAX_HEADS) && (def_s16 <= MAX_SECTORS);
    if ((total_sectors_r == '0) || (total_sectors_r > {3'd0, LBA28_LIMIT})) begin
      tlim = LBA28_LIMIT;
    end else begin
      tlim = total_sectors_r[28:0];
    end

    s1_nxt      = '0;
    s1_nxt.drv  = in_drive_select;
    s1_nxt.lba  = in_start_sector;
    s1_nxt.cnt  = in_sector_count;
    s1_nxt.tlim = tlim;
    if (!id_flags_r[0]) begin
      s1_nxt.mode = MODE_NONE;
    end else if (id_flags_r[1]) begin
      s1_nxt.mode = MODE_LBA28;
    end else if (cur_ok) begin
      s1_nxt.mode = MODE_CUR;
      s1_nxt.hd   = cur_heads_r[4:0];
      s1_nxt.sp   = cur_sectors_r[7:0];
      s1_nxt.cyl  = {1'b0, cur_cylinders_r};
    end else if (def_fit) begin
      s1_nxt.mode = MODE_DEF;
      s1_nxt.hd   = def_h16[4:0];
      s1_nxt.sp   = def_s16[7:0];
      s1_nxt.cyl  = (def_cylinders_r == '0) ? CYL_DEFAULT : {1'b0, def_cylinders_r};
    end else begin
      s1_nxt.mode = MODE_NONE;
    end
    s1_nxt.hs = 12'({7'd0, s1_nxt.hd} * {4'd0, s1_nxt.sp});
  end

  // Stage 2: sector limit of the chosen mode.
  always_comb begin
    s2_nxt.drv  = s1_r.drv;
    s2_nxt.mode = s1_r.mode;
    s2_nxt.hd   = s1_r.hd;
    s2_nxt.sp   = s1_r.sp;
    s2_nxt.hs   = s1_r.hs;
    s2_nxt.lba  = s1_r.lba;
    s2_nxt.cnt  = s1_r.cnt;
    case (s1_r.mode)
      MODE_NONE:  s2_nxt.lim = '0;
      MODE_LBA28: s2_nxt.lim = s1_r.tlim;
      default:    s2_nxt.lim = 29'({12'd0, s1_r.cyl} * {17'd0, s1_r.hs});
    endcase
  end

  // Stage 3: start against the limit and the headroom left above it.
  always_comb begin
    s3_nxt.drv  = s2_r.drv;
    s3_nxt.mode = s2_r.mode;
    s3_nxt.hd   = s2_r.hd;
    s3_nxt.sp   = s2_r.sp;
    s3_nxt.hs   = s2_r.hs;
    s3_nxt.lim  = s2_r.lim;
    s3_nxt.lba  = s2_r.lba;
    s3_nxt.cnt  = s2_r.cnt;
    s3_nxt.lt   = s2_r.lba < {3'd0, s2_r.lim};
    s3_nxt.diff = s2_r.lim - s2_r.lba[28:0];
  end

  // Entry to the cylinder divider: status, count check, first partial remainder.
  always_comb begin
    dv_first        = '0;
    dv_first.drv    = s3_r.drv;
    dv_first.mode   = s3_r.mode;
    dv_first.hd     = s3_r.hd;
    dv_first.sp     = s3_r.sp;
    dv_first.hs     = s3_r.hs;
    dv_first.lim    = s3_r.lim;
    dv_first.lba    = s3_r.lba[LBA_BITS-1:0];
    dv_first.rem    = s3_r.lba[LBA_BITS-1:CYL_BITS];
    if (s3_r.mode == MODE_NONE) begin
      dv_first.status = ST_NO_DRIVE;
    end else if (!s3_r.lt) begin
      dv_first.status = ST_RANGE;
    end else begin
      dv_first.status = ST_OK;
    end
    dv_first.rok = (s3_r.mode != MODE_NONE) &&
                   ((s3_r.cnt == '0) || (s3_r.lt && (s3_r.cnt <= {3'd0, s3_r.diff})));
  end

  // Cylinder divider: one quotient bit per stage.
  always_comb begin
    dv_in[0] = dv_first;
    for (int k = 1; k < CYL_BITS; k++) begin
      dv_in[k] = dv_r[k-1];
    end
    for (int k = 0; k < CYL_BITS; k++) begin
      cyl_step[k]   = div_step12(dv_in[k].rem, dv_in[k].lba[CYL_BITS-1-k], dv_in[k].hs);
      dv_nxt[k]     = dv_in[k];
      dv_nxt[k].quo = {dv_in[k].quo[CYL_BITS-2:0], cyl_step[k].q};
      dv_nxt[k].rem = cyl_step[k].rem;
    end
  end

  // Head divider: the track remainder split by sectors, one head bit per stage.
  always_comb begin
    hr_in[0]      = dv_r[CYL_BITS-1];
    hr_in[0].rem  = {4'd0, dv_r[CYL_BITS-1].rem[REM_BITS-1:HEAD_BITS]};
    hr_in[0].low  = dv_r[CYL_BITS-1].rem[HEAD_BITS-1:0];
    hr_in[0].head = '0;
    for (int j = 1; j < HEAD_BITS; j++) begin
      hr_in[j] = hr_r[j-1];
    end
    for (int j = 0; j < HEAD_BITS; j++) begin
      head_step[j]   = div_step8(hr_in[j].rem[7:0], hr_in[j].low[HEAD_BITS-1-j], hr_in[j].sp);
      hr_nxt[j]      = hr_in[j];
      hr_nxt[j].head = {hr_in[j].head[HEAD_BITS-2:0], head_step[j].q};
      hr_nxt[j].rem  = {4'd0, head_step[j].rem};
    end
  end

  // Task-file bytes from the last divider stage.
  always_comb begin
    slave_bit  = hr_r[HEAD_BITS-1].drv ? DH_SLAVE : 8'd0;
    status_nxt = hr_r[HEAD_BITS-1].status;
    mode_nxt   = hr_r[HEAD_BITS-1].mode;
    rok_nxt    = hr_r[HEAD_BITS-1].rok;
    hd_nxt     = hr_r[HEAD_BITS-1].hd;
    sp_nxt     = hr_r[HEAD_BITS-1].sp;
    lim_nxt    = hr_r[HEAD_BITS-1].lim;
    if (hr_r[HEAD_BITS-1].status != ST_OK) begin
      b0_nxt = '0;
      b1_nxt = '0;
      b2_nxt = '0;
      b3_nxt = '0;
    end else if (hr_r[HEAD_BITS-1].mode == MODE_LBA28) begin
      b0_nxt = hr_r[HEAD_BITS-1].lba[7:0];
      b1_nxt = hr_r[HEAD_BITS-1].lba[15:8];
      b2_nxt = hr_r[HEAD_BITS-1].lba[23:16];
      b3_nxt = DH_BASE | DH_LBA | slave_bit | {4'd0, hr_r[HEAD_BITS-1].lba[27:24]};
    end else begin
      b0_nxt = hr_r[HEAD_BITS-1].rem[7:0] + 8'd1;
      b1_nxt = hr_r[HEAD_BITS-1].quo[7:0];
      b2_nxt = hr_r[HEAD_BITS-1].quo[15:8];
      b3_nxt = DH_BASE | slave_bit | {4'd0, hr_r[HEAD_BITS-1].head};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    for (int k = 0; k < CYL_BITS; k++) begin
      dv_r[k] <= dv_nxt[k];
    end
    for (int j = 0; j < HEAD_BITS; j++) begin
      hr_r[j] <= hr_nxt[j];
    end
    status_r <= status_nxt;
    mode_r   <= mode_nxt;
    rok_r    <= rok_nxt;
    b0_r     <= b0_nxt;
    b1_r     <= b1_nxt;
    b2_r     <= b2_nxt;
    b3_r     <= b3_nxt;
    hd_r     <= hd_nxt;
    sp_r     <= sp_nxt;
    lim_r    <= lim_nxt;
  end

  // Result ports.
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_addr_mode     = mode_r;
  assign out_range_ok      = rok_r;
  assign out_sector_number = b0_r;
  assign out_cylinder_low  = b1_r;
  assign out_cylinder_high = b2_r;
  assign out_drive_head    = b3_r;
  assign out_heads_used    = hd_r;
  assign out_sectors_used  = sp_r;
  assign out_sector_limit  = lim_r;

endmodule

`default_nettype wire

@@ hdl/ase_checker.sv @@
// Port-level checks for the ATA sector address encoder, bound to its top level.
`default_nettype none

module ase_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic [1:0]  out_addr_mode,
  input wire logic [7:0]  out_sector_number,
  input wire logic [7:0]  out_cylinder_low,
  input wire logic [7:0]  out_cylinder_high,
  input wire logic [7:0]  out_drive_head,
  input wire logic [4:0]  out_heads_used,
  input wire logic [7:0]  out_sectors_used
);
  import ase_pkg::*;

  // Every accepted transaction comes out after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("accepted transaction produced no result at the pipeline latency");

  // No result appears without a transaction accepted one latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a matching accepted transaction");

  // The no-drive status goes with exactly the no-mode selection.
  a_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_addr_mode == MODE_NONE) == (out_status == ST_NO_DRIVE)))
    else $error("no-drive status and mode selection disagree");

  // A failed transaction carries an all-zero task file.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_sector_number == 8'd0) && (out_cylinder_low == 8'd0) &&
      (out_cylinder_high == 8'd0) && (out_drive_head == 8'd0))
    else $error("task file bytes nonzero on a failed transaction");

  // LBA28 mode reports no CHS geometry.
  a_lba_geom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_addr_mode == MODE_LBA28)) |->
      (out_heads_used == 5'd0) && (out_sectors_used == 8'd0))
    else $error("CHS geometry reported in LBA28 mode");

endmodule

bind ata_sector_address_encoder_top ase_checker u_ase_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the ATA sector address encoder: geometry, range check and task file.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ase_pkg::*;

  // One command transaction.
  typedef struct packed {
    logic        drv;
    logic [31:0] lba;
    logic [31:0] cnt;
  } addr_item_t;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  mode;
    logic        rok;
    logic [7:0]  sn;
    logic [7:0]  cl;
    logic [7:0]  ch;
    logic [7:0]  dh;
    logic [4:0]  hd;
    logic [7:0]  sp;
    logic [28:0] lim;
  } addr_result_t;

  // Identify geometry as held in the configuration registers.
  typedef struct packed {
    logic [2:0]  flags;
    logic [31:0] total;
    logic [15:0] cur_h;
    logic [15:0] cur_s;
    logic [15:0] cur_c;
    logic [15:0] def_h;
    logic [15:0] def_s;
    logic [15:0] def_c;
  } drive_geometry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_drive_select = 1'b0;
  logic [31:0] in_start_sector = '0;
  logic [31:0] in_sector_count = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [1:0]  out_addr_mode;
  logic        out_range_ok;
  logic [7:0]  out_sector_number;
  logic [7:0]  out_cylinder_low;
  logic [7:0]  out_cylinder_high;
  logic [7:0]  out_drive_head;
  logic [4:0]  out_heads_used;
  logic [7:0]  out_sectors_used;
  logic [28:0] out_sector_limit;

  ata_sector_address_encoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_drive_select   (in_drive_select),
    .in_start_sector   (in_start_sector),
    .in_sector_count   (in_sector_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_addr_mode     (out_addr_mode),
    .out_range_ok      (out_range_ok),
    .out_sector_number (out_sector_number),
    .out_cylinder_low  (out_cylinder_low),
    .out_cylinder_high (out_cylinder_high),
    .out_drive_head    (out_drive_head),
    .out_heads_used    (out_heads_used),
    .out_sectors_used  (out_sectors_used),
    .out_sector_limit  (out_sector_limit)
  );

  // Testbench state.
  drive_geometry_t drive_geo = '0;
  addr_item_t      pending_cmds[$];
  addr_result_t    expected_results[$];
  bit              in_taken;
  int unsigned     gap_left;
  int unsigned     gap_pct;
  int unsigned     items_queued;
  int unsigned     results_checked;
  int unsigned     error_count;
  int unsigned     settings_used;
  int unsigned     range_errors;
  int unsigned     range_passes;
  int unsigned     mode_count[4];

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pick the addressing mode and the geometry that goes with it.
  function automatic logic [1:0] choose_geometry(output longint unsigned hd,
                                                 output longint unsigned sp,
                                                 output longint unsigned lim);
    longint unsigned h, s, c;
    hd  = 0;
    sp  = 0;
    lim = 0;
    if (!drive_geo.flags[0]) return MODE_NONE;
    if (drive_geo.flags[1]) begin
      lim = drive_geo.total;
      if (lim == 0 || lim > LBA28_LIMIT) lim = LBA28_LIMIT;
      return MODE_LBA28;
    end
    if (drive_geo.flags[2] && drive_geo.cur_h >= 1 && drive_geo.cur_h <= MAX_HEADS &&
        drive_geo.cur_s >= 1 && drive_geo.cur_s <= MAX_SECTORS && drive_geo.cur_c >= 1) begin
      hd  = drive_geo.cur_h;
      sp  = drive_geo.cur_s;
      lim = longint'(drive_geo.cur_c) * hd * sp;
      return MODE_CUR;
    end
    // Default geometry, with the assumed values standing in for zero fields.
    h = (drive_geo.def_h != 0) ? drive_geo.def_h : FALLBACK_HEADS;
    s = (drive_geo.def_s != 0) ? drive_geo.def_s : FALLBACK_SECTORS;
    if (h > MAX_HEADS || s > MAX_SECTORS) return MODE_NONE;
    c = (drive_geo.def_c != 0) ? drive_geo.def_c : CYL_DEFAULT;
    hd  = h;
    sp  = s;
    lim = c * h * s;
    return MODE_DEF;
  endfunction

  // Expected task-file result for one command under the current geometry.
  function automatic addr_result_t predict_task_file(addr_item_t it);
    addr_result_t    r;
    longint unsigned hd, sp, lim, lba, cnt, trk, sec, hnum, cyl;
    logic [1:0]      mode;
    logic [7:0]      slave;
    r     = '0;
    mode  = choose_geometry(hd, sp, lim);
    lba   = it.lba;
    cnt   = it.cnt;
    slave = it.drv ? DH_SLAVE : 8'h00;
    r.mode = mode;
    r.hd   = hd[4:0];
    r.sp   = sp[7:0];
    r.lim  = lim[28:0];
    if (mode == MODE_NONE) begin
      r.status = ST_NO_DRIVE;
    end else begin
      // Range check written so that start plus count never overflows.
      r.rok = (cnt == 0) || (lba < lim && cnt <= lim - lba);
      if (lba >= lim) begin
        r.status = ST_RANGE;
      end else if (mode == MODE_LBA28) begin
        r.sn = lba[7:0];
        r.cl = lba[15:8];
        r.ch = lba[23:16];
        r.dh = DH_BASE | DH_LBA | slave | {4'h0, lba[27:24]};
      end else if (hd == 0 || sp == 0) begin
        r.status = ST_RANGE;
      end else begin
        trk  = lba / sp;
        sec  = lba % sp + 1;
        hnum = trk % hd;
        cyl  = trk / hd;
        if (cyl > CYL_DEFAULT - 1) begin
          r.status = ST_RANGE;
        end else begin
          r.sn = sec[7:0];
          r.cl = cyl[7:0];
          r.ch = cyl[15:8];
          r.dh = DH_BASE | slave | {4'h0, hnum[3:0]};
        end
      end
    end
    return r;
  endfunction

  function automatic drive_geometry_t make_geometry(logic [2:0] f, logic [31:0] t,
                                                    logic [15:0] ch, logic [15:0] cs,
                                                    logic [15:0] cc, logic [15:0] dh,
                                                    logic [15:0] ds, logic [15:0] dc);
    drive_geometry_t g;
    g.flags = f;
    g.total = t;
    g.cur_h = ch;
    g.cur_s = cs;
    g.cur_c = cc;
    g.def_h = dh;
    g.def_s = ds;
    g.def_c = dc;
    return g;
  endfunction

  // Random geometry, weighted toward settings that select a mode.
  function automatic drive_geometry_t random_geometry();
    drive_geometry_t g;
    int unsigned     kind;
    g.flags = 3'($urandom);
    g.total = $urandom;
    g.cur_h = 16'($urandom);
    g.cur_s = 16'($urandom);
    g.cur_c = 16'($urandom);
    g.def_h = 16'($urandom);
    g.def_s = 16'($urandom);
    g.def_c = 16'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      0: g.flags[0] = 1'b0;
      1, 2: begin
        g.flags[1:0] = 2'b11;
        case ($urandom_range(0, 7))
          0: g.total = 32'd0;
          1: g.total = 32'd1;
          2: g.total = 32'(LBA28_LIMIT) - 32'd1;
          3: g.total = 32'(LBA28_LIMIT);
          4: g.total = 32'(LBA28_LIMIT) + 32'd1;
          5: g.total = 32'hFFFF_FFFF;
          6: g.total = $urandom_range(1, 4096);
          default: g.total = $urandom;
        endcase
      end
      3, 4, 5: begin
        g.flags = 3'b101;
        g.cur_h = 16'($urandom_range(1, 16));
        g.cur_s = 16'($urandom_range(1, 255));
        case ($urandom_range(0, 3))
          0: g.cur_c = 16'd1;
          1: g.cur_c = 16'hFFFF;
          2: g.cur_c = 16'($urandom_range(1, 8));
          default: g.cur_c = 16'($urandom_range(1, 65535));
        endcase
        // One kind in three breaks a current field, so the default geometry wins.
        if (kind == 5) begin
          g.def_h = 16'($urandom_range(0, 16));
          g.def_s = 16'($urandom_range(0, 255));
          case ($urandom_range(0, 4))
            0: g.cur_h = 16'd0;
            1: g.cur_h = 16'($urandom_range(17, 65535));
            2: g.cur_s = 16'd0;
            3: g.cur_s = 16'($urandom_range(256, 65535));
            default: g.cur_c = 16'd0;
          endcase
        end
      end
      6, 7: begin
        g.flags = {1'($urandom), 2'b01};
        g.def_h = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 16));
        g.def_s = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 0) g.def_c = 16'd0;
      end
      8: begin
        g.flags = 3'b001;
        if ($urandom_range(0, 1) == 0) g.def_h = 16'($urandom_range(17, 65535));
        else g.def_s = 16'($urandom_range(256, 65535));
      end
      default: ;
    endcase
    return g;
  endfunction

  // Random command, biased toward the edges of the sector limit.
  function automatic addr_item_t random_item(longint unsigned lim);
    addr_item_t      it;
    longint unsigned room;
    it.drv = 1'($urandom);
    case ($urandom_range(0, 9))
      0: it.lba = 32'd0;
      1: it.lba = 32'(lim - 1);
      2: it.lba = 32'(lim);
      3: it.lba = $urandom;
      4: it.lba = 32'hFFFF_FFFF;
      default: it.lba = (lim > 0) ? $urandom_range(0, 32'(lim - 1)) : $urandom;
    endcase
    room = (it.lba < lim) ? lim - it.lba : 0;
    case ($urandom_range(0, 7))
      0: it.cnt = 32'd0;
      1: it.cnt = 32'd1;
      2: it.cnt = 32'(room);
      3: it.cnt = 32'(room + 1);
      4: it.cnt = $urandom;
      5: it.cnt = 32'hFFFF_FFFF;
      6: it.cnt = $urandom_range(1, 256);
      default: it.cnt = $urandom_range(0, 32'(room));
    endcase
    return it;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 30) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                             results_checked, name, got, want));
  endtask

  // Command driver: holds each transaction until it is taken, with random idle bursts.
  always @(negedge clk) begin : cmd_driver
    addr_item_t it;
    bit         go;
    if (!(start && !in_taken)) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        it = pending_cmds.pop_front();
        in_drive_select <= it.drv;
        in_start_sector <= it.lba;
        in_sector_count <= it.cnt;
        go = 1'b1;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 10);
      end
      start <= go;
    end
  end

  // Result monitor: checks each strobed result and predicts each accepted command.
  always @(posedge clk) begin : result_monitor
    addr_result_t want;
    addr_item_t   it;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_error("result strobe with no transaction outstanding");
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("status", out_status, want.status);
          check_field("addr_mode", out_addr_mode, want.mode);
          check_field("range_ok", out_range_ok, want.rok);
          check_field("sector_number", out_sector_number, want.sn);
          check_field("cylinder_low", out_cylinder_low, want.cl);
          check_field("cylinder_high", out_cylinder_high, want.ch);
          check_field("drive_head", out_drive_head, want.dh);
          check_field("heads_used", out_heads_used, want.hd);
          check_field("sectors_used", out_sectors_used, want.sp);
          check_field("sector_limit", out_sector_limit, want.lim);
          mode_count[want.mode]++;
          if (want.status == ST_RANGE) range_errors++;
          if (want.rok) range_passes++;
        end
      end else if (out_valid !== 1'b0) begin
        report_error("out_valid is unknown");
      end
      if (start && !busy) begin
        in_taken = 1'b1;
        it.drv = in_drive_select;
        it.lba = in_start_sector;
        it.cnt = in_sector_count;
        expected_results.push_back(predict_task_file(it));
      end
    end
  end

  // One register write; the local copy changes at the accepting edge.
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_ID_FLAGS:      drive_geo.flags = data[2:0];
      REG_TOTAL_SECTORS: drive_geo.total = data;
      REG_CUR_HEADS:     drive_geo.cur_h = data[15:0];
      REG_CUR_SECTORS:   drive_geo.cur_s = data[15:0];
      REG_CUR_CYLINDERS: drive_geo.cur_c = data[15:0];
      REG_DEF_HEADS:     drive_geo.def_h = data[15:0];
      REG_DEF_SECTORS:   drive_geo.def_s = data[15:0];
      REG_DEF_CYLINDERS: drive_geo.def_c = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Noise in the unused upper bits must be ignored by the narrow registers.
  task automatic load_geometry(input drive_geometry_t g);
    cfg_write(REG_ID_FLAGS, {29'($urandom), g.flags});
    cfg_write(REG_TOTAL_SECTORS, g.total);
    cfg_write(REG_CUR_HEADS, {16'($urandom), g.cur_h});
    cfg_write(REG_CUR_SECTORS, {16'($urandom), g.cur_s});
    cfg_write(REG_CUR_CYLINDERS, {16'($urandom), g.cur_c});
    cfg_write(REG_DEF_HEADS, {16'($urandom), g.def_h});
    cfg_write(REG_DEF_SECTORS, {16'($urandom), g.def_s});
    cfg_write(REG_DEF_CYLINDERS, {16'($urandom), g.def_c});
  endtask

  task automatic queue_item(input addr_item_t it);
    pending_cmds.push_back(it);
    items_queued++;
  endtask

  // Every command yields one result, so idle means every queued one is checked.
  task automatic wait_idle();
    while (results_checked != items_queued) @(negedge clk);
  endtask

  // One geometry setting followed by its commands.
  task automatic run_phase(input drive_geometry_t g, input int n_random, input bit edges);
    longint unsigned hd, sp, lim;
    wait_idle();
    load_geometry(g);
    settings_used++;
    void'(choose_geometry(hd, sp, lim));
    if (edges) begin
      queue_item({1'b1, 32'(lim - 1), 32'd1});
      queue_item({1'b0, 32'(lim), 32'd0});
      queue_item({1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    end
    for (int i = 0; i < n_random; i++) queue_item(random_item(lim));
  endtask

  function automatic int unsigned pick_gap_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 12;
      default: return 35;
    endcase
  endfunction

  // Stimulus sequence.
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed settings: no geometry, LBA28 caps, largest current CHS,
    // broken current CHS with all fallbacks, oversized default, one-sector disk.
    gap_pct = pick_gap_pct();
    run_phase(make_geometry(3'b000, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0, 1);
    run_phase(make_geometry(3'b011, 32'd0, 16'd4, 16'd17, 16'd100, 16'd0, 16'd0, 16'd0),
              0, 1);
    run_phase(make_geometry(3'b111, 32'hFFFF_FFFF, 16'd16, 16'd63, 16'd10, 16'd2, 16'd2,
                            16'd2), 0, 1);
    run_phase(make_geometry(3'b101, 32'd5000, 16'd16, 16'd255, 16'hFFFF, 16'd1, 16'd1,
                            16'd1), 0, 1);
    run_phase(make_geometry(3'b101, 32'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0),
              0, 1);
    run_phase(make_geometry(3'b001, 32'd7, 16'd2, 16'd2, 16'd2, 16'hFFFF, 16'hFFFF,
                            16'hFFFF), 0, 1);
    run_phase(make_geometry(3'b001, 32'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1), 0, 1);

    // Random settings, the last one with no idle cycles.
    for (int p = 0; p < 12; p++) begin
      gap_pct = (p == 11) ? 0 : pick_gap_pct();
      run_phase(random_geometry(), 78, 0);
    end

    wait_idle();
    repeat (PIPE_LATENCY + 4) @(negedge clk);

    $display("Checked %0d results over %0d geometry settings: none %0d, LBA28 %0d, current CHS %0d, default CHS %0d.",
             results_checked, settings_used, mode_count[MODE_NONE], mode_count[MODE_LBA28],
             mode_count[MODE_CUR], mode_count[MODE_DEF]);
    $display("%0d starts were out of range, %0d range checks passed, %0d errors.",
             range_errors, range_passes, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Timeout with %0d of %0d results checked.", results_checked, items_queued);
    $display("TEST FAILED");
    $finish;
  end

endmodule
